>>> rtl/core/sbd_pkg.sv
// Shared types and constants for the silence block detector.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package sbd_pkg;

   // Frame counter width default (legal range 16 to 48)
   localparam int POSITION_BITS_DEFAULT = 32;

   // Field widths fixed by the interface
   localparam int SAMPLE_BITS   = 32;
   localparam int OUT_POS_BITS  = 32;
   localparam int BPS_BITS      = 3;
   localparam int THRESH_BITS   = 31;
   localparam int RUN_LEN_BITS  = 32;
   localparam int BLOCK_BITS    = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register index map
   localparam logic [CSR_IDX_BITS-1:0] CSR_BYTES_PER_SAMPLE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MONO_MODE        = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NOISE_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_RUN_LENGTH   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_BLOCKS       = 3'd4;

   // Sample width codes
   localparam logic [BPS_BITS-1:0] BPS_8BIT  = 3'd1;
   localparam logic [BPS_BITS-1:0] BPS_16BIT = 3'd2;
   localparam logic [BPS_BITS-1:0] BPS_24BIT = 3'd3;
   localparam logic [BPS_BITS-1:0] BPS_32BIT = 3'd4;

   // Register reset values
   localparam logic [BPS_BITS-1:0]     RESET_BYTES_PER_SAMPLE = BPS_16BIT;
   localparam logic                    RESET_MONO_MODE        = 1'b0;
   localparam logic [THRESH_BITS-1:0]  RESET_NOISE_THRESHOLD  = 31'd80;
   localparam logic [RUN_LEN_BITS-1:0] RESET_MIN_RUN_LENGTH   = 32'd44100;
   localparam logic [BLOCK_BITS-1:0]   RESET_MAX_BLOCKS       = 8'd100;

   typedef struct packed {
      logic [BPS_BITS-1:0]     bytes_per_sample;
      logic                    mono_mode;
      logic [THRESH_BITS-1:0]  noise_threshold;
      logic [RUN_LEN_BITS-1:0] min_run_length;
      logic [BLOCK_BITS-1:0]   max_blocks;
   } sbd_cfg_type;

   typedef struct packed {
      logic                    block_valid;
      logic [OUT_POS_BITS-1:0] block_start;
      logic [OUT_POS_BITS-1:0] block_end;
      logic [BLOCK_BITS-1:0]   block_index;
      logic                    overflow;
      logic                    stream_done;
      logic                    none_found;
   } sbd_result_type;

endpackage

`default_nettype wire

>>> rtl/core/sbd_ifs.sv
// Valid/ready channel interfaces for frame requests, results and register writes.
// Depends on sbd_pkg for field widths.
`default_nettype none

interface sbd_req_if import sbd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] left_raw;
   logic [SAMPLE_BITS-1:0] right_raw;
   logic                   last_frame;

   modport source (output valid, output left_raw, output right_raw, output last_frame,
                   input ready);
   modport sink   (input valid, input left_raw, input right_raw, input last_frame,
                   output ready);
endinterface

interface sbd_rsp_if import sbd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    block_valid;
   logic [OUT_POS_BITS-1:0] block_start;
   logic [OUT_POS_BITS-1:0] block_end;
   logic [BLOCK_BITS-1:0]   block_index;
   logic                    overflow;
   logic                    stream_done;
   logic                    none_found;

   modport source (output valid, output block_valid, output block_start, output block_end,
                   output block_index, output overflow, output stream_done,
                   output none_found, input ready);
   modport sink   (input valid, input block_valid, input block_start, input block_end,
                   input block_index, input overflow, input stream_done,
                   input none_found, output ready);
endinterface

interface sbd_csr_if import sbd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/silence_block_detector.sv
// Top level of the silence block detector: request register, run tracker, result register.
// Depends on sbd_pkg, the sbd_*_if interfaces, sbd_sample_check and sbd_run_tracker.
`default_nettype none

// Finds runs of quiet PCM frames. Each request carries one frame (left and right raw
// bytes plus a last-frame flag); a result is produced when a run of at least
// min_run_length frames closes, and always for the last frame of a stream. A request
// is taken every clock cycle while results are taken: it lands in an input register,
// from which the sample unpack, threshold compare and run update retire it into the
// result register. A waiting result stalls only frames that also produce a result.
// Register writes are always accepted and must be made while no frame is in flight.
module silence_block_detector
   import sbd_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   sbd_req_if.sink    req_ch,
   sbd_rsp_if.source  rsp_ch,
   sbd_csr_if.sink    csr_ch
);

   sbd_cfg_type            cfg_ff, cfg_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_left_ff;
   logic [SAMPLE_BITS-1:0] s1_right_ff;
   logic                   s1_last_ff;

   logic                   out_valid_ff, out_valid_in;
   sbd_result_type         out_ff;

   logic                   quiet;
   logic                   has_result;
   sbd_result_type         result;
   logic                   advance;
   logic                   req_take;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BYTES_PER_SAMPLE: cfg_in.bytes_per_sample = csr_ch.data[BPS_BITS-1:0];
            CSR_MONO_MODE:        cfg_in.mono_mode        = csr_ch.data[0];
            CSR_NOISE_THRESHOLD:  cfg_in.noise_threshold  = csr_ch.data[THRESH_BITS-1:0];
            CSR_MIN_RUN_LENGTH:   cfg_in.min_run_length   = csr_ch.data[RUN_LEN_BITS-1:0];
            CSR_MAX_BLOCKS:       cfg_in.max_blocks       = csr_ch.data[BLOCK_BITS-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_sample <= RESET_BYTES_PER_SAMPLE;
         cfg_ff.mono_mode        <= RESET_MONO_MODE;
         cfg_ff.noise_threshold  <= RESET_NOISE_THRESHOLD;
         cfg_ff.min_run_length   <= RESET_MIN_RUN_LENGTH;
         cfg_ff.max_blocks       <= RESET_MAX_BLOCKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Retire the held request unless its result would overwrite a waiting one
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready || !has_result);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   // Request register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_left_ff  <= req_ch.left_raw;
         s1_right_ff <= req_ch.right_raw;
         s1_last_ff  <= req_ch.last_frame;
      end
   end

   sbd_sample_check u_check (
      .left_raw  (s1_left_ff),
      .right_raw (s1_right_ff),
      .cfg       (cfg_ff),
      .quiet     (quiet)
   );

   sbd_run_tracker #(
      .POSITION_BITS (POSITION_BITS)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .quiet      (quiet),
      .last_frame (s1_last_ff),
      .cfg        (cfg_ff),
      .has_result (has_result),
      .result     (result)
   );

   // Result register: drop on take, load on a retiring frame with a result
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && has_result) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.block_valid = out_ff.block_valid;
   assign rsp_ch.block_start = out_ff.block_start;
   assign rsp_ch.block_end   = out_ff.block_end;
   assign rsp_ch.block_index = out_ff.block_index;
   assign rsp_ch.overflow    = out_ff.overflow;
   assign rsp_ch.stream_done = out_ff.stream_done;
   assign rsp_ch.none_found  = out_ff.none_found;

`ifndef SYNTHESIS
   // A request taken while one is held must coincide with the held one retiring
   assert property (@(posedge clock) disable iff (reset)
      (req_take && s1_valid_ff) |-> advance)
      else $error("request register overwritten");

   // A stalled result is never replaced
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |-> !(advance && has_result))
      else $error("waiting result overwritten");

   // An empty report only comes at stream end
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.none_found) |-> (out_ff.stream_done && !out_ff.block_valid))
      else $error("none_found outside stream end");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sbd_sample_check.sv
// Unpacks both raw channel samples to left-justified signed values and tests them
// against the noise threshold. Depends on sbd_pkg.
`default_nettype none

module sbd_sample_check
   import sbd_pkg::*;
(
   input  wire logic [SAMPLE_BITS-1:0] left_raw,
   input  wire logic [SAMPLE_BITS-1:0] right_raw,
   input  wire sbd_cfg_type            cfg,
   output logic                        quiet
);

   logic [SAMPLE_BITS-1:0] left_val;
   logic [SAMPLE_BITS-1:0] right_val;
   logic                   left_quiet;
   logic                   right_quiet;
   logic signed [SAMPLE_BITS:0] pos_limit;
   logic signed [SAMPLE_BITS:0] neg_limit;

   // Left-justify one channel; unknown widths read as zero
   function automatic logic [SAMPLE_BITS-1:0] unpack(input logic [SAMPLE_BITS-1:0] raw,
                                                     input logic [BPS_BITS-1:0] bps);
      logic [SAMPLE_BITS-1:0] val;
      unique case (bps)
         BPS_8BIT:  val = {~raw[7], raw[6:0], 24'd0};
         BPS_16BIT: val = {raw[15:0], 16'd0};
         BPS_24BIT: val = {raw[23:0], 8'd0};
         BPS_32BIT: val = raw;
         default:   val = '0;
      endcase
      return val;
   endfunction

   // Test a value against +/- threshold in 33-bit signed arithmetic
   function automatic logic in_band(input logic [SAMPLE_BITS-1:0] v,
                                    input logic signed [SAMPLE_BITS:0] hi,
                                    input logic signed [SAMPLE_BITS:0] lo);
      logic signed [SAMPLE_BITS:0] v_ext;
      v_ext = $signed({v[SAMPLE_BITS-1], v});
      return (v_ext <= hi) && (v_ext >= lo);
   endfunction

   always_comb begin
      pos_limit   = $signed({2'b00, cfg.noise_threshold});
      neg_limit   = -pos_limit;
      left_val    = unpack(left_raw, cfg.bytes_per_sample);
      right_val   = unpack(right_raw, cfg.bytes_per_sample);
      left_quiet  = in_band(left_val, pos_limit, neg_limit);
      // Mono treats the right channel as silent
      right_quiet = cfg.mono_mode || in_band(right_val, pos_limit, neg_limit);
      quiet       = left_quiet && right_quiet;
   end

endmodule

`default_nettype wire

>>> rtl/core/sbd_run_tracker.sv
// Frame counter and quiet-run state; builds the result for the frame being retired.
// Depends on sbd_pkg.
`default_nettype none

module sbd_run_tracker
   import sbd_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic           quiet,
   input  wire logic           last_frame,
   input  wire sbd_cfg_type    cfg,
   output logic                has_result,
   output sbd_result_type      result
);

   localparam int CMP_BITS = (POSITION_BITS > RUN_LEN_BITS) ? POSITION_BITS : RUN_LEN_BITS;

   logic [POSITION_BITS-1:0] frame_pos_ff,  frame_pos_in;
   logic                     in_run_ff,     in_run_in;
   logic [POSITION_BITS-1:0] run_start_ff,  run_start_in;
   logic [BLOCK_BITS-1:0]    blocks_ff,     blocks_in;
   logic                     halted_ff,     halted_in;

   logic                     run_open;
   logic                     close_run;
   logic                     report;
   logic [POSITION_BITS-1:0] start_pos;
   logic [POSITION_BITS-1:0] end_pos;
   logic [POSITION_BITS-1:0] run_len;
   logic [BLOCK_BITS-1:0]    blocks_inc;
   logic                     halt_now;
   logic [CMP_BITS-1:0]      start_ext;
   logic [CMP_BITS-1:0]      end_ext;

   // Run bookkeeping for the current frame
   always_comb begin
      run_open   = !halted_ff && (in_run_ff || quiet);
      start_pos  = (in_run_ff) ? run_start_ff : frame_pos_ff;
      close_run  = run_open && (!quiet || last_frame);
      // A quiet last frame belongs to the run; a loud frame ends it
      end_pos    = quiet ? frame_pos_ff + 1'b1 : frame_pos_ff;
      run_len    = end_pos - start_pos;
      report     = close_run &&
                   (CMP_BITS'(run_len) >= CMP_BITS'(cfg.min_run_length));
      blocks_inc = blocks_ff + 1'b1;
      halt_now   = report && (blocks_inc >= cfg.max_blocks);
      start_ext  = CMP_BITS'(start_pos);
      end_ext    = CMP_BITS'(end_pos);
   end

   // Next state; the last frame returns the stream state to zero
   always_comb begin
      frame_pos_in = frame_pos_ff + 1'b1;
      in_run_in    = run_open && !close_run;
      run_start_in = run_open ? start_pos : run_start_ff;
      blocks_in    = report ? blocks_inc : blocks_ff;
      halted_in    = halted_ff || halt_now;
      if (last_frame) begin
         frame_pos_in = '0;
         in_run_in    = 1'b0;
         run_start_in = '0;
         blocks_in    = '0;
         halted_in    = 1'b0;
      end
   end

   // Result for this frame
   always_comb begin
      has_result         = report || last_frame;
      result.block_valid = report;
      result.block_start = report ? start_ext[OUT_POS_BITS-1:0] : '0;
      result.block_end   = report ? end_ext[OUT_POS_BITS-1:0] : '0;
      result.block_index = report ? blocks_ff : '0;
      result.overflow    = halted_ff || halt_now;
      result.stream_done = last_frame;
      result.none_found  = last_frame && ((report ? blocks_inc : blocks_ff) == '0);
   end

   // Advance state when a frame retires
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= '0;
         in_run_ff    <= 1'b0;
         run_start_ff <= '0;
         blocks_ff    <= '0;
         halted_ff    <= 1'b0;
      end else if (advance) begin
         frame_pos_ff <= frame_pos_in;
         in_run_ff    <= in_run_in;
         run_start_ff <= run_start_in;
         blocks_ff    <= blocks_in;
         halted_ff    <= halted_in;
      end
   end

`ifndef SYNTHESIS
   // The last frame leaves the stream state cleared
   assert property (@(posedge clock) disable iff (reset)
      (advance && last_frame) |=>
         (frame_pos_ff == '0 && !in_run_ff && blocks_ff == '0 && !halted_ff))
      else $error("stream state not cleared after last frame");

   // No run is reported once detection has stopped
   assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !report)
      else $error("run reported while halted");

   // A halted tracker never holds an open run
   assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !in_run_ff)
      else $error("open run kept while halted");
`endif

endmodule

`default_nettype wire
